// ----- src/dedup_sort_min_max_top_assert.svh -----
// assertion macros shared by the checker
`ifndef DEDUP_SORT_MIN_MAX_TOP_ASSERT_SVH
`define DEDUP_SORT_MIN_MAX_TOP_ASSERT_SVH

// same-cycle implication
`define DSMM_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dsmm assertion failed");

// next-cycle implication
`define DSMM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dsmm assertion failed");

`endif

// ----- src/dsmm_pkg.sv -----
// shared types and result field widths
`timescale 1ns / 1ps

package dsmm_pkg;

   localparam int unsigned SORTED_W = 16;
   localparam int unsigned POS_W    = 5;
   localparam int unsigned COUNT_W  = 6;

   typedef struct packed {
      logic insert;
      logic shift;
   } dsmm_ctrl_type;

endpackage

// ----- src/dsmm_cell.sv -----
// one cell of the sorted value chain
`timescale 1ns / 1ps

module dsmm_cell #(
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  logic                          clock,
   input  dsmm_pkg::dsmm_ctrl_type       ctrl,
   input  logic                          vld,
   input  logic signed [VALUE_WIDTH-1:0] ins_value,
   input  logic signed [VALUE_WIDTH-1:0] prev_val,
   input  logic                          prev_vld,
   input  logic                          prev_lt,
   input  logic signed [VALUE_WIDTH-1:0] next_val,
   output logic signed [VALUE_WIDTH-1:0] val,
   output logic                          lt,
   output logic                          eq
);

   logic signed [VALUE_WIDTH-1:0] val_ff;
   logic signed [VALUE_WIDTH-1:0] val_in;

   assign val = val_ff;
   assign lt  = vld && (val_ff < ins_value);
   assign eq  = vld && (val_ff == ins_value);

   always_comb begin
      val_in = val_ff;
      if (ctrl.shift) begin
         val_in = next_val;
      end else if (ctrl.insert) begin
         if (lt) begin
            val_in = val_ff;
         end else if (prev_vld && !prev_lt) begin
            val_in = prev_val;
         end else if (prev_vld) begin
            val_in = ins_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

// ----- src/dedup_sort_min_max_top.sv -----
// an item is absorbed in the cycle it transfers; after last the state register enters drain
// throughput: one item per cycle while filling; while draining one result per unstalled cycle
// a run of n kept values blocks input until all n results have loaded, result stalls included
// the chain of DEPTH compare cells sets the rate: one insert or one unstalled shift per cycle
// reset: synchronous, clears count, overflow flag, state and result valid
`timescale 1ns / 1ps

module dedup_sort_min_max_top #(
   parameter int unsigned DEPTH       = 32,
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [VALUE_WIDTH-1:0]         req_value,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [dsmm_pkg::SORTED_W-1:0]  rsp_sorted_value,
   output logic        [dsmm_pkg::POS_W-1:0]     rsp_position,
   output logic                                  rsp_final_res,
   output logic        [dsmm_pkg::COUNT_W-1:0]   rsp_unique_count,
   output logic signed [dsmm_pkg::SORTED_W-1:0]  rsp_max_value,
   output logic        [dsmm_pkg::COUNT_W-1:0]   rsp_max_rank,
   output logic signed [dsmm_pkg::SORTED_W-1:0]  rsp_min_value,
   output logic                                  rsp_overflow
);

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned PW = (CW > dsmm_pkg::COUNT_W) ? CW : dsmm_pkg::COUNT_W;
   localparam int unsigned OW = (VALUE_WIDTH > dsmm_pkg::SORTED_W) ?
                                VALUE_WIDTH : dsmm_pkg::SORTED_W;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          ovf_ff, ovf_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic signed [dsmm_pkg::SORTED_W-1:0] min_ff, min_in;
   logic signed [dsmm_pkg::SORTED_W-1:0] value_ff, value_in;
   logic        [dsmm_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic                                 fin_ff, fin_in;
   logic        [dsmm_pkg::COUNT_W-1:0]  ucnt_ff, ucnt_in;
   logic signed [dsmm_pkg::SORTED_W-1:0] max_ff, max_in;
   logic                                 rovf_ff, rovf_in;

   logic signed [VALUE_WIDTH-1:0] cell_val [DEPTH];
   logic [DEPTH-1:0]              cell_lt;
   logic [DEPTH-1:0]              cell_eq;
   logic [DEPTH-1:0]              cell_vld;
   dsmm_pkg::dsmm_ctrl_type       ctrl;

   logic                          req_xfer;
   logic                          dup;
   logic                          full;
   logic                          load;
   logic                          last_one;
   logic [OW-1:0]                 head_ext;
   logic signed [dsmm_pkg::SORTED_W-1:0] head_value;
   logic [PW-1:0]                 idx_ext;
   logic [PW-1:0]                 count_ext;

   assign req_stall = (state_ff != ST_FILL);
   assign req_xfer  = req_valid && !req_stall;
   assign dup       = |cell_eq;
   assign full      = (count_ff == CW'(DEPTH));
   assign load      = (state_ff == ST_DRAIN) && (!rsp_valid_ff || !rsp_stall);
   assign last_one  = (idx_ff == (count_ff - CW'(1)));

   assign ctrl.insert = req_xfer && !dup && !full;
   assign ctrl.shift  = load;

   assign head_ext   = OW'($unsigned(cell_val[0]));
   assign head_value = head_ext[dsmm_pkg::SORTED_W-1:0];
   assign idx_ext    = PW'(idx_ff);
   assign count_ext  = PW'(count_ff);

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic signed [VALUE_WIDTH-1:0] prev_val;
         logic                          prev_vld;
         logic                          prev_lt;
         logic signed [VALUE_WIDTH-1:0] next_val;

         assign cell_vld[gi] = (count_ff > CW'(gi));

         if (gi == 0) begin : g_head
            assign prev_val = '0;
            assign prev_vld = 1'b1;
            assign prev_lt  = 1'b1;
         end else begin : g_body
            assign prev_val = cell_val[gi-1];
            assign prev_vld = cell_vld[gi-1];
            assign prev_lt  = cell_lt[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_tail
            assign next_val = '0;
         end else begin : g_inner
            assign next_val = cell_val[gi+1];
         end

         dsmm_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
         ) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .vld       (cell_vld[gi]),
            .ins_value (req_value),
            .prev_val  (prev_val),
            .prev_vld  (prev_vld),
            .prev_lt   (prev_lt),
            .next_val  (next_val),
            .val       (cell_val[gi]),
            .lt        (cell_lt[gi]),
            .eq        (cell_eq[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      min_in       = min_ff;
      value_in     = value_ff;
      pos_in       = pos_ff;
      fin_in       = fin_ff;
      ucnt_in      = ucnt_ff;
      max_in       = max_ff;
      rovf_in      = rovf_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_FILL: begin
            if (req_xfer) begin
               if (ctrl.insert) begin
                  count_in = count_ff + CW'(1);
               end else if (!dup) begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  idx_in   = '0;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               value_in     = head_value;
               pos_in       = idx_ext[dsmm_pkg::POS_W-1:0];
               fin_in       = last_one;
               ucnt_in      = '0;
               max_in       = '0;
               rovf_in      = 1'b0;
               idx_in       = idx_ff + CW'(1);
               if (idx_ff == '0) begin
                  min_in = head_value;
               end
               if (last_one) begin
                  ucnt_in  = count_ext[dsmm_pkg::COUNT_W-1:0];
                  max_in   = head_value;
                  rovf_in  = ovf_ff;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         count_ff     <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      min_ff   <= min_in;
      value_ff <= value_in;
      pos_ff   <= pos_in;
      fin_ff   <= fin_in;
      ucnt_ff  <= ucnt_in;
      max_ff   <= max_in;
      rovf_ff  <= rovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = value_ff;
   assign rsp_position     = pos_ff;
   assign rsp_final_res    = fin_ff;
   assign rsp_unique_count = ucnt_ff;
   assign rsp_max_value    = max_ff;
   assign rsp_max_rank     = ucnt_ff;
   assign rsp_min_value    = fin_ff ? min_ff : '0;
   assign rsp_overflow     = rovf_ff;

endmodule

// ----- src/dsmm_checker.sv -----
// port-level checker for the sorted set block, with its bind
`timescale 1ns / 1ps
`include "dedup_sort_min_max_top_assert.svh"

module dsmm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [dsmm_pkg::SORTED_W-1:0]  rsp_sorted_value,
   input logic                                  rsp_final_res,
   input logic        [dsmm_pkg::COUNT_W-1:0]   rsp_unique_count,
   input logic signed [dsmm_pkg::SORTED_W-1:0]  rsp_max_value,
   input logic        [dsmm_pkg::COUNT_W-1:0]   rsp_max_rank,
   input logic                                  rsp_overflow
);

   `DSMM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sorted_value) && $stable(rsp_final_res))
   `DSMM_ASSERT_NOW(a_rank_is_count, rsp_valid && rsp_final_res, rsp_max_rank == rsp_unique_count)
   `DSMM_ASSERT_NOW(a_max_is_last, rsp_valid && rsp_final_res, rsp_max_value == rsp_sorted_value)
   `DSMM_ASSERT_NOW(a_summary_only_final, rsp_valid && !rsp_final_res, rsp_unique_count == '0 && !rsp_overflow)

endmodule

bind dedup_sort_min_max_top dsmm_checker u_dsmm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sorted_value (rsp_sorted_value),
   .rsp_final_res    (rsp_final_res),
   .rsp_unique_count (rsp_unique_count),
   .rsp_max_value    (rsp_max_value),
   .rsp_max_rank     (rsp_max_rank),
   .rsp_overflow     (rsp_overflow)
);

// ----- tb/dedup_sort_min_max_checker.sv -----
// checker for dedup_sort_min_max_top: predicts each sorted run and compares every result transfer
`timescale 1ns / 1ps

module dedup_sort_min_max_checker #(
   parameter int unsigned DEPTH       = 32,
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [VALUE_WIDTH-1:0]         req_value,
   input  logic                                  req_last,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [dsmm_pkg::SORTED_W-1:0]  rsp_sorted_value,
   input  logic        [dsmm_pkg::POS_W-1:0]     rsp_position,
   input  logic                                  rsp_final_res,
   input  logic        [dsmm_pkg::COUNT_W-1:0]   rsp_unique_count,
   input  logic signed [dsmm_pkg::SORTED_W-1:0]  rsp_max_value,
   input  logic        [dsmm_pkg::COUNT_W-1:0]   rsp_max_rank,
   input  logic signed [dsmm_pkg::SORTED_W-1:0]  rsp_min_value,
   input  logic                                  rsp_overflow,
   output int                                    mismatch_count,
   output int                                    pending_results
);

   localparam int unsigned SW = dsmm_pkg::SORTED_W;

   typedef struct {
      logic signed [dsmm_pkg::SORTED_W-1:0] sorted_value;
      logic        [dsmm_pkg::POS_W-1:0]    position;
      logic                                 final_res;
      logic        [dsmm_pkg::COUNT_W-1:0]  unique_count;
      logic signed [dsmm_pkg::SORTED_W-1:0] max_value;
      logic        [dsmm_pkg::COUNT_W-1:0]  max_rank;
      logic signed [dsmm_pkg::SORTED_W-1:0] min_value;
      logic                                 overflow;
   } sorted_entry_type;

   sorted_entry_type              pending_sorted[$];
   logic signed [VALUE_WIDTH-1:0] kept_values[$];
   logic                          run_overflowed;

   function automatic void note_mismatch(string what, int want, int got);
      if (mismatch_count < 10)
         $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
      mismatch_count++;
   endfunction

   // insert into the sorted set, and on last queue the whole run in ascending order
   function automatic void absorb_value(logic signed [VALUE_WIDTH-1:0] v, logic last_flag);
      int               slot;
      bit               seen;
      int               n;
      bit               fin;
      sorted_entry_type e;
      slot = 0;
      seen = 1'b0;
      foreach (kept_values[i]) begin
         if (kept_values[i] == v)
            seen = 1'b1;
         else if (kept_values[i] < v)
            slot = i + 1;
      end
      if (!seen) begin
         if (kept_values.size() >= DEPTH)
            run_overflowed = 1'b1;
         else
            kept_values.insert(slot, v);
      end
      if (last_flag) begin
         n = kept_values.size();
         for (int k = 0; k < n; k++) begin
            fin = (k == n - 1);
            e.sorted_value = SW'($unsigned(kept_values[k]));
            e.position     = k[dsmm_pkg::POS_W-1:0];
            e.final_res    = fin;
            e.unique_count = fin ? n[dsmm_pkg::COUNT_W-1:0] : '0;
            e.max_value    = fin ? SW'($unsigned(kept_values[n-1])) : '0;
            e.max_rank     = fin ? n[dsmm_pkg::COUNT_W-1:0] : '0;
            e.min_value    = fin ? SW'($unsigned(kept_values[0])) : '0;
            e.overflow     = fin && run_overflowed;
            pending_sorted.push_back(e);
         end
         kept_values.delete();
         run_overflowed = 1'b0;
      end
   endfunction

   function automatic void check_sorted_result();
      sorted_entry_type e;
      if (pending_sorted.size() == 0) begin
         if (mismatch_count < 10)
            $display("mismatch at %0t: result transfer with none expected, sorted_value %0d",
                     $time, rsp_sorted_value);
         mismatch_count++;
      end else begin
         e = pending_sorted.pop_front();
         if (rsp_sorted_value !== e.sorted_value)
            note_mismatch("sorted_value", e.sorted_value, rsp_sorted_value);
         if (rsp_position !== e.position)
            note_mismatch("position", e.position, rsp_position);
         if (rsp_final_res !== e.final_res)
            note_mismatch("final_res", e.final_res, rsp_final_res);
         if (rsp_unique_count !== e.unique_count)
            note_mismatch("unique_count", e.unique_count, rsp_unique_count);
         if (rsp_max_value !== e.max_value)
            note_mismatch("max_value", e.max_value, rsp_max_value);
         if (rsp_max_rank !== e.max_rank)
            note_mismatch("max_rank", e.max_rank, rsp_max_rank);
         if (rsp_min_value !== e.min_value)
            note_mismatch("min_value", e.min_value, rsp_min_value);
         if (rsp_overflow !== e.overflow)
            note_mismatch("overflow", e.overflow, rsp_overflow);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pending_sorted.delete();
         kept_values.delete();
         run_overflowed = 1'b0;
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_sorted_result();
         if (req_valid && !req_stall)
            absorb_value(req_value, req_last);
      end
      pending_results = pending_sorted.size();
   end

endmodule

// ----- tb/testbench.sv -----
// top of the testbench: clock, reset, stimulus, receiver stalls, watchdog and verdict
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned DEPTH          = 32;
   localparam int unsigned VALUE_WIDTH    = 16;
   localparam int          TOTAL_ITEMS    = 105;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          SETTLE_CYCLES  = 40;

   typedef enum {RUN_SHORT, RUN_POOL, RUN_FULL, RUN_OVERFLOW} run_kind_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic signed [VALUE_WIDTH-1:0]        req_value = '0;
   logic                                 req_last = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [dsmm_pkg::SORTED_W-1:0] rsp_sorted_value;
   logic        [dsmm_pkg::POS_W-1:0]    rsp_position;
   logic                                 rsp_final_res;
   logic        [dsmm_pkg::COUNT_W-1:0]  rsp_unique_count;
   logic signed [dsmm_pkg::SORTED_W-1:0] rsp_max_value;
   logic        [dsmm_pkg::COUNT_W-1:0]  rsp_max_rank;
   logic signed [dsmm_pkg::SORTED_W-1:0] rsp_min_value;
   logic                                 rsp_overflow;

   int   mismatch_count;
   int   pending_results;
   int   items_sent = 0;
   int   quiet_cycles = 0;
   int   stall_hold = 0;
   bit   send_gaps_on = 1'b1;
   bit   rsp_stalls_on = 1'b1;

   logic signed [VALUE_WIDTH-1:0] pool_values [6] =
      '{16'sh8000, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh7FFF, 16'sh0005};

   dedup_sort_min_max_top #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_position     (rsp_position),
      .rsp_final_res    (rsp_final_res),
      .rsp_unique_count (rsp_unique_count),
      .rsp_max_value    (rsp_max_value),
      .rsp_max_rank     (rsp_max_rank),
      .rsp_min_value    (rsp_min_value),
      .rsp_overflow     (rsp_overflow)
   );

   dedup_sort_min_max_checker #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_position     (rsp_position),
      .rsp_final_res    (rsp_final_res),
      .rsp_unique_count (rsp_unique_count),
      .rsp_max_value    (rsp_max_value),
      .rsp_max_rank     (rsp_max_rank),
      .rsp_min_value    (rsp_min_value),
      .rsp_overflow     (rsp_overflow),
      .mismatch_count   (mismatch_count),
      .pending_results  (pending_results)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // mostly short, now and then long
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   always @(negedge clock) begin
      if (reset || !rsp_stalls_on) begin
         rsp_stall <= 1'b0;
         stall_hold = 0;
      end else if (stall_hold > 0) begin
         stall_hold--;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_hold = $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b1;
         stall_hold = pick_pause();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(input logic signed [VALUE_WIDTH-1:0] v, input logic l);
      int pause;
      pause = send_gaps_on ? pick_pause() : 0;
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= l;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_run(input run_kind_type kind);
      logic [VALUE_WIDTH-1:0] walk;
      logic [VALUE_WIDTH-1:0] stride;
      logic [VALUE_WIDTH-1:0] first;
      int                     count;
      send_gaps_on = ($urandom_range(0, 3) != 0);
      rsp_stalls_on <= ($urandom_range(0, 3) != 0);
      if (kind == RUN_FULL || kind == RUN_OVERFLOW) begin
         // odd stride walks through distinct values
         first  = VALUE_WIDTH'($urandom);
         stride = VALUE_WIDTH'($urandom) | 16'h0001;
         walk   = first;
         count  = (kind == RUN_FULL) ? DEPTH : DEPTH + $urandom_range(1, 6);
         for (int i = 0; i < count; i++) begin
            if (i > 0 && $urandom_range(0, 7) == 0)
               send_item(first, 1'b0);
            send_item(walk, i == count - 1);
            walk = walk + stride;
         end
      end else begin
         count = $urandom_range(1, 10);
         for (int i = 0; i < count; i++) begin
            if (kind == RUN_POOL)
               send_item(pool_values[3'($urandom_range(0, 5))], i == count - 1);
            else
               send_item(VALUE_WIDTH'($urandom), i == count - 1);
         end
      end
   endtask

   initial begin
      int           r;
      run_kind_type kind;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single value
      send_item(16'sh0000, 1'b1);
      // extremes out of order
      send_item(16'sh7FFF, 1'b0);
      send_item(16'sh8000, 1'b0);
      send_item(16'shFFFF, 1'b0);
      send_item(16'sh0000, 1'b0);
      send_item(16'sh0001, 1'b1);
      // duplicates, last one a duplicate
      send_item(16'sh0005, 1'b0);
      send_item(16'sh0005, 1'b0);
      send_item(16'shFFFD, 1'b0);
      send_item(16'sh0005, 1'b0);
      send_item(16'shFFFD, 1'b1);
      send_item(16'sh8000, 1'b1);
      send_item(16'sh7FFF, 1'b1);
      // descending
      send_item(16'sh0003, 1'b0);
      send_item(16'sh0002, 1'b0);
      send_item(16'sh0001, 1'b1);
      send_item(16'sh0004, 1'b0);
      send_item(16'sh0004, 1'b1);

      send_run(RUN_OVERFLOW);
      send_run(RUN_FULL);
      while (items_sent < TOTAL_ITEMS) begin
         r = $urandom_range(0, 9);
         if (r == 0)
            kind = RUN_OVERFLOW;
         else if (r == 1)
            kind = RUN_FULL;
         else if (r < 6)
            kind = RUN_POOL;
         else
            kind = RUN_SHORT;
         send_run(kind);
      end
      req_valid <= 1'b0;

      while (pending_results != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_results == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
